>>> hw/rtl/ebp_pkg.sv
// shared types and constants for the edge-balanced partitioner
// no dependencies; used by the interfaces, the divider, the top level and the checker
package ebp_pkg;

	localparam int unsigned PartW = 6;
	localparam int unsigned VertW = 12;
	localparam int unsigned OffW = 32;
	localparam int unsigned SumW = OffW + 1;
	localparam int unsigned TgtW = SumW + PartW;
	localparam int unsigned MemDepth = 4096;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned EvenFactorW = 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_PARTITION_COUNT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_VERTEX_COUNT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_EDGE_COUNT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PER,
		ST_EMIT,
		ST_NEXT,
		ST_QDIV,
		ST_RD_M,
		ST_GOT_M,
		ST_GOT_B,
		ST_DEC,
		ST_FIX
	} state_t;

	typedef struct packed {
		logic start;
		logic [SumW-1:0] dividend;
		logic [PartW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [SumW-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/ebp_if.sv
// stream and register-write interfaces of the partitioner
// depends on ebp_pkg
interface ebp_cmd_if;
	logic valid;
	logic ready;
	logic command;
	logic [ebp_pkg::VertW-1:0] offset_index;
	logic [ebp_pkg::OffW-1:0] offset_value;
	modport source (output valid, command, offset_index, offset_value, input ready);
	modport sink (input valid, command, offset_index, offset_value, output ready);
endinterface

interface ebp_border_if;
	logic valid;
	logic ready;
	logic [ebp_pkg::PartW-1:0] border_index;
	logic [ebp_pkg::VertW-1:0] border_value;
	logic last;
	modport source (output valid, border_index, border_value, last, input ready);
	modport sink (input valid, border_index, border_value, last, output ready);
endinterface

interface ebp_cfg_if;
	logic valid;
	logic ready;
	logic [ebp_pkg::CfgIdxW-1:0] index;
	logic [ebp_pkg::OffW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/csr_edge_balanced_partitioner.sv
// top level of the edge-balanced partitioner: offset store, sequencer, output register
// depends on ebp_pkg, ebp_if and ebp_divider
//
// channels: cmd takes items; a load item (command 0) writes offset_value at
// offset_index into the offset store, one per cycle while idle, with no result. a run item
// (command 1) emits borders 0 to P on the border channel, last set on border P.
// cfg writes partition_count, vertex_count and edge_count, always ready; write
// only while the block is idle.
// throughput: loads one item per cycle while idle. a run holds cmd.ready low until the last
// border is in the output register. search mode first waits on the shared divider
// for the edge share, then per inner border runs probes of the binary search, each
// through the read, compare and decide states (one store read port, two reads per
// probe), about 12 probes. even split mode waits on the divider once per inner border
// while vertices remain. each border passes through the emit and step states.
// receiver stall: the output register holds its border; the sequencer waits in
// its emit step, no border is dropped.
// reset: control state and output valid clear; the offset store is undefined
// until loaded and needs no clearing pass.
module csr_edge_balanced_partitioner (
	input  logic clk,
	input  logic arst_n,
	ebp_cmd_if.sink cmd,
	ebp_border_if.source border,
	ebp_cfg_if.sink cfg
);
	localparam int unsigned PW = ebp_pkg::PartW;
	localparam int unsigned VW = ebp_pkg::VertW;
	localparam int unsigned TW = ebp_pkg::TgtW;

	// configuration registers
	logic [PW-1:0] pc_q;
	logic [VW-1:0] vc_q;
	logic [ebp_pkg::OffW-1:0] ec_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PW'(1);
			vc_q <= VW'(1);
			ec_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ebp_pkg::REG_PARTITION_COUNT: pc_q <= cfg.data[PW-1:0];
				ebp_pkg::REG_VERTEX_COUNT: vc_q <= cfg.data[VW-1:0];
				ebp_pkg::REG_EDGE_COUNT: ec_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// offset store, one write and one registered read port
	logic [ebp_pkg::OffW-1:0] mem [ebp_pkg::MemDepth];
	logic [VW-1:0] rd_addr;
	logic [ebp_pkg::OffW-1:0] rd_data_q;
	logic mem_we;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[cmd.offset_index] <= cmd.offset_value;
		rd_data_q <= mem[rd_addr];
	end

	// sequencer state
	ebp_pkg::state_t state_q, state_d;
	logic [PW-1:0] t_q, t_d, p_q, p_d, rem_p_q, rem_p_d;
	logic [VW-1:0] v_q, v_d, rem_v_q, rem_v_d, bval_q, bval_d;
	logic [VW-1:0] lo_q, lo_d, hi_q, hi_d, m_q, m_d;
	logic [VW:0] prev_q, prev_d;
	logic [ebp_pkg::SumW-1:0] per_q, per_d;
	logic [TW-1:0] target_q, target_d, mv_q, mv_d;
	logic even_q, even_d;

	// output register
	logic out_valid_q, out_valid_d;
	logic [PW-1:0] out_idx_q, out_idx_d;
	logic [VW-1:0] out_val_q, out_val_d;
	logic out_last_q, out_last_d;

	ebp_pkg::div_req_t div_req;
	ebp_pkg::div_rsp_t div_rsp;

	ebp_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// datapath helpers
	logic [PW-1:0] p_sat;
	logic [VW-1:0] v_sat;
	logic [TW-1:0] mv_now, bv_now;
	logic [VW-1:0] m_dec;
	logic [VW-1:0] lo_n, hi_n, nm;
	logic [VW:0] lohi_sum;
	logic [VW:0] mfix_a, mfix;
	logic [VW-1:0] q_even;

	assign p_sat = (pc_q == '0) ? PW'(1) : pc_q;
	assign v_sat = (vc_q == '0) ? VW'(1) : vc_q;
	assign m_dec = m_q - 1'b1;
	assign mv_now = TW'(rd_data_q) + TW'(m_q);
	assign bv_now = TW'(rd_data_q) + TW'(m_dec);
	assign lo_n = (mv_q > target_q) ? lo_q : m_q;
	assign hi_n = (mv_q > target_q) ? m_q : hi_q;
	assign lohi_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign nm = lohi_sum[VW:1];
	// strictly above the previous border, never past V
	assign mfix_a = ({1'b0, m_q} <= prev_q) ? (prev_q + 1'b1) : {1'b0, m_q};
	assign mfix = (mfix_a > {1'b0, v_q}) ? {1'b0, v_q} : mfix_a;
	// even split step is at least one vertex
	assign q_even = (div_rsp.quotient == '0) ? VW'(1) : div_rsp.quotient[VW-1:0];

	assign cmd.ready = (state_q == ebp_pkg::ST_IDLE);
	assign mem_we = cmd.valid && cmd.ready && (cmd.command == ebp_pkg::CMD_LOAD);

	always_comb begin
		state_d = state_q;
		t_d = t_q;
		p_d = p_q;
		v_d = v_q;
		rem_p_d = rem_p_q;
		rem_v_d = rem_v_q;
		bval_d = bval_q;
		lo_d = lo_q;
		hi_d = hi_q;
		m_d = m_q;
		prev_d = prev_q;
		per_d = per_q;
		target_d = target_q;
		mv_d = mv_q;
		even_d = even_q;
		div_req.start = 1'b0;
		div_req.dividend = {ebp_pkg::SumW{1'b0}};
		div_req.divisor = {PW{1'b0}};
		rd_addr = m_q;
		out_valid_d = out_valid_q && !border.ready;
		out_idx_d = out_idx_q;
		out_val_d = out_val_q;
		out_last_d = out_last_q;

		unique case (state_q)
			ebp_pkg::ST_IDLE: begin
				if (cmd.valid && cmd.command == ebp_pkg::CMD_RUN) begin
					p_d = p_sat;
					v_d = v_sat;
					t_d = '0;
					prev_d = '0;
					rem_v_d = v_sat;
					rem_p_d = p_sat;
					bval_d = '0;
					target_d = '0;
					even_d = ({2'b0, v_sat} <= {p_sat, {ebp_pkg::EvenFactorW{1'b0}}});
					if (even_d) begin
						state_d = ebp_pkg::ST_EMIT;
					end else begin
						div_req.start = 1'b1;
						div_req.dividend = ebp_pkg::SumW'(ec_q) + ebp_pkg::SumW'(v_sat);
						div_req.divisor = p_sat;
						state_d = ebp_pkg::ST_PER;
					end
				end
			end
			ebp_pkg::ST_PER: begin
				if (div_rsp.done) begin
					per_d = div_rsp.quotient;
					state_d = ebp_pkg::ST_EMIT;
				end
			end
			ebp_pkg::ST_EMIT: begin
				if (!out_valid_q || border.ready) begin
					out_valid_d = 1'b1;
					out_idx_d = t_q;
					out_val_d = bval_q;
					out_last_d = (t_q == p_q);
					if (t_q == p_q) begin
						state_d = ebp_pkg::ST_IDLE;
					end else begin
						t_d = t_q + 1'b1;
						state_d = ebp_pkg::ST_NEXT;
					end
				end
			end
			ebp_pkg::ST_NEXT: begin
				if (t_q == p_q) begin
					bval_d = v_q;
					state_d = ebp_pkg::ST_EMIT;
				end else if (even_q) begin
					rem_p_d = rem_p_q - 1'b1;
					if (rem_v_q == '0) begin
						bval_d = v_q;
						state_d = ebp_pkg::ST_EMIT;
					end else begin
						div_req.start = 1'b1;
						div_req.dividend = ebp_pkg::SumW'(rem_v_q);
						div_req.divisor = rem_p_q;
						state_d = ebp_pkg::ST_QDIV;
					end
				end else begin
					target_d = target_q + TW'(per_q);
					lo_d = '0;
					hi_d = v_q;
					m_d = v_q >> 1;
					state_d = ebp_pkg::ST_RD_M;
				end
			end
			ebp_pkg::ST_QDIV: begin
				if (div_rsp.done) begin
					bval_d = prev_q[VW-1:0] + q_even;
					prev_d = {1'b0, bval_d};
					rem_v_d = rem_v_q - q_even;
					state_d = ebp_pkg::ST_EMIT;
				end
			end
			ebp_pkg::ST_RD_M: begin
				rd_addr = m_q;
				state_d = ebp_pkg::ST_GOT_M;
			end
			ebp_pkg::ST_GOT_M: begin
				rd_addr = m_dec;
				mv_d = mv_now;
				if (mv_now == target_q)
					state_d = ebp_pkg::ST_FIX;
				else if (m_q != '0)
					state_d = ebp_pkg::ST_GOT_B;
				else
					state_d = ebp_pkg::ST_DEC;
			end
			ebp_pkg::ST_GOT_B: begin
				if (bv_now < target_q && mv_q > target_q)
					state_d = ebp_pkg::ST_FIX;
				else
					state_d = ebp_pkg::ST_DEC;
			end
			ebp_pkg::ST_DEC: begin
				lo_d = lo_n;
				hi_d = hi_n;
				if (nm == m_q) begin
					state_d = ebp_pkg::ST_FIX;
				end else begin
					m_d = nm;
					state_d = ebp_pkg::ST_RD_M;
				end
			end
			ebp_pkg::ST_FIX: begin
				bval_d = mfix[VW-1:0];
				prev_d = mfix;
				state_d = ebp_pkg::ST_EMIT;
			end
			default: state_d = ebp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ebp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		t_q <= t_d;
		p_q <= p_d;
		v_q <= v_d;
		rem_p_q <= rem_p_d;
		rem_v_q <= rem_v_d;
		bval_q <= bval_d;
		lo_q <= lo_d;
		hi_q <= hi_d;
		m_q <= m_d;
		prev_q <= prev_d;
		per_q <= per_d;
		target_q <= target_d;
		mv_q <= mv_d;
		even_q <= even_d;
		out_idx_q <= out_idx_d;
		out_val_q <= out_val_d;
		out_last_q <= out_last_d;
	end

	assign border.valid = out_valid_q;
	assign border.border_index = out_idx_q;
	assign border.border_value = out_val_q;
	assign border.last = out_last_q;
endmodule

>>> hw/rtl/ebp_divider.sv
// restoring divider, one quotient bit per cycle
// depends on ebp_pkg
module ebp_divider (
	input  logic clk,
	input  logic arst_n,
	input  ebp_pkg::div_req_t req,
	output ebp_pkg::div_rsp_t rsp
);
	localparam int unsigned CntW = $clog2(ebp_pkg::SumW + 1);

	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic [ebp_pkg::SumW-1:0] quo_q;
	logic [ebp_pkg::PartW:0] rem_q;
	logic [ebp_pkg::PartW-1:0] dsr_q;
	logic done_q;
	logic [ebp_pkg::PartW:0] trial;
	logic [ebp_pkg::PartW:0] diff;

	assign trial = {rem_q[ebp_pkg::PartW-1:0], quo_q[ebp_pkg::SumW-1]};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(ebp_pkg::SumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff;
				quo_q <= {quo_q[ebp_pkg::SumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[ebp_pkg::SumW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

>>> hw/rtl/ebp_checker.sv
// port-level checks for the partitioner, bound to the top level
// depends on ebp_pkg
module ebp_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic cmd_command,
	input logic out_valid,
	input logic out_ready,
	input logic [ebp_pkg::PartW-1:0] out_index,
	input logic [ebp_pkg::VertW-1:0] out_value,
	input logic out_last
);
	// stalled border holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value))
		else $error("stalled border changed");

	// a run keeps the command side closed
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_command == ebp_pkg::CMD_RUN |=> !cmd_ready)
		else $error("command taken during a run");

	// more borders follow an inner one, so the block stays busy
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |-> !cmd_ready)
		else $error("idle with borders outstanding");

	// border 0 is vertex 0 and never the last
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_index == '0 |-> out_value == '0 && !out_last)
		else $error("bad first border");
endmodule

bind csr_edge_balanced_partitioner ebp_checker u_ebp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.cmd_command(cmd.command),
	.out_valid(border.valid),
	.out_ready(border.ready),
	.out_index(border.border_index),
	.out_value(border.border_value),
	.out_last(border.last)
);

>>> sim/tb_csr_edge_balanced_partitioner.sv
// self-checking testbench for csr_edge_balanced_partitioner
// depends on ebp_pkg, the ebp interfaces and the rtl top level; holds its own border predictor
module tb_csr_edge_balanced_partitioner;

	localparam int unsigned CycleLimit = 6000000;
	localparam int unsigned StoreDepth = 4096;
	localparam int unsigned PW = ebp_pkg::PartW;
	localparam int unsigned VW = ebp_pkg::VertW;
	localparam int unsigned OW = ebp_pkg::OffW;
	localparam int unsigned CW = ebp_pkg::CfgIdxW;

	typedef struct packed {
		logic [PW-1:0] index;
		logic [VW-1:0] value;
		logic last;
	} border_t;

	logic clk;
	logic arst_n;

	ebp_cmd_if cmd_ch();
	ebp_border_if bord_ch();
	ebp_cfg_if cfg_ch();

	csr_edge_balanced_partitioner u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.border(bord_ch),
		.cfg(cfg_ch)
	);

	// predictor copy of the block: register file and offset store
	logic [PW-1:0] parts_reg;
	logic [VW-1:0] verts_reg;
	logic [OW-1:0] edges_reg;
	logic [OW-1:0] offsets [StoreDepth];
	bit loaded [StoreDepth];

	border_t expected_borders[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned burst_left;
	int unsigned stall_pct;
	bit hold_req;
	bit hold_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("** csr_edge_balanced_partitioner: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic longint unsigned read_offset(longint unsigned idx);
		if (idx >= StoreDepth)
			return 0;
		return offsets[idx];
	endfunction

	// binary search for the vertex whose offset plus index meets the target;
	// the first vertex has no predecessor so its bracket test is skipped
	function automatic longint unsigned find_border(longint unsigned target,
			longint unsigned nv);
		longint unsigned lo, hi, m, mv, bv, nm;
		lo = 0;
		hi = nv;
		m = (lo + hi) / 2;
		forever begin
			mv = read_offset(m) + m;
			if (mv == target)
				break;
			if (m > 0) begin
				bv = read_offset(m - 1) + (m - 1);
				if (bv < target && mv > target)
					break;
			end
			if (mv > target)
				hi = m;
			else
				lo = m;
			nm = (lo + hi) / 2;
			if (nm == m)
				break;
			m = nm;
		end
		return m;
	endfunction

	function automatic void predict_borders();
		longint unsigned np, nv, per, prev, m, rem_v, rem_p, q;
		longint unsigned b [64];
		border_t item;
		np = (parts_reg == 0) ? 1 : parts_reg;
		nv = (verts_reg == 0) ? 1 : verts_reg;
		b[0] = 0;
		b[np] = nv;
		if (nv <= 4 * np) begin
			// even split: each inner border advances by at least one vertex until V is reached
			rem_v = nv;
			rem_p = np;
			for (int t = 1; t < np; t++) begin
				if (rem_v > 0) begin
					q = rem_v / rem_p;
					if (q < 1)
						q = 1;
					b[t] = b[t-1] + q;
					rem_v -= q;
				end else begin
					b[t] = nv;
				end
				rem_p--;
			end
		end else begin
			per = (longint'(edges_reg) + nv) / np;
			prev = 0;
			for (int t = 1; t < np; t++) begin
				m = find_border(t * per, nv);
				if (m <= prev)
					m = prev + 1;
				if (m > nv)
					m = nv;
				b[t] = m;
				prev = m;
			end
		end
		for (int t = 0; t <= np; t++) begin
			item.index = t[PW-1:0];
			item.value = b[t][VW-1:0];
			item.last = (t == np);
			expected_borders.push_back(item);
		end
	endfunction

	// a search run reads entries 0 to V-1, all of which must have been loaded
	function automatic bit run_is_safe();
		int unsigned nv;
		nv = (verts_reg == 0) ? 1 : verts_reg;
		if (nv <= 4 * ((parts_reg == 0) ? 1 : parts_reg))
			return 1;
		for (int i = 0; i < nv; i++)
			if (!loaded[i])
				return 0;
		return 1;
	endfunction

	// ---------------------------------------------------------------
	// border checker and receiver stall pattern
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		border_t got, want;
		if (arst_n && bord_ch.valid && bord_ch.ready) begin
			got.index = bord_ch.border_index;
			got.value = bord_ch.border_value;
			got.last = bord_ch.last;
			if (expected_borders.size() == 0) begin
				$display("%0t unexpected border: expected none, actual idx %0d val %0d last %0b",
					$time, got.index, got.value, got.last);
				errors++;
			end else begin
				want = expected_borders.pop_front();
				if (got.index !== want.index) begin
					$display("%0t border_index mismatch: expected %0d, actual %0d",
						$time, want.index, got.index);
					errors++;
				end
				if (got.value !== want.value) begin
					$display("%0t border_value mismatch (border %0d): expected %0d, actual %0d",
						$time, want.index, want.value, got.value);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t last mismatch (border %0d): expected %0b, actual %0b",
						$time, want.index, want.last, got.last);
					errors++;
				end
			end
		end
		// stall pattern is redrawn periodically, with no-stall stretches
		if (cycles % 150 == 0) begin
			case ($urandom_range(0, 4))
				0, 1: stall_pct = 0;
				2: stall_pct = 25;
				3: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		if (hold_on)
			bord_ch.ready <= 1'b0;
		else
			bord_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		hold_on = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_on = 1;
				repeat (600) @(posedge clk);
				hold_on = 0;
				hold_req = 0;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus tasks; all are entered at a rising edge
	// ---------------------------------------------------------------

	// one command item, with bursts and random gaps on the sender side
	task automatic send_cmd(logic c, logic [VW-1:0] idx, logic [OW-1:0] val);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.offset_index <= idx;
		cmd_ch.offset_value <= val;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		// item taken at this edge
		if (c == ebp_pkg::CMD_LOAD) begin
			offsets[idx] = val;
			loaded[idx] = 1;
		end else begin
			predict_borders();
		end
	endtask

	task automatic load_entry(int unsigned idx, logic [OW-1:0] val);
		send_cmd(ebp_pkg::CMD_LOAD, idx[VW-1:0], val);
	endtask

	task automatic run_partition();
		logic [31:0] rnd_idx;
		logic [OW-1:0] rnd_val;
		rnd_idx = $urandom;
		rnd_val = $urandom;
		send_cmd(ebp_pkg::CMD_RUN, rnd_idx[VW-1:0], rnd_val);
	endtask

	// drain everything, then let a load still in flight settle
	task automatic wait_quiet();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_borders.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CW-1:0] idx, logic [OW-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			ebp_pkg::REG_PARTITION_COUNT: parts_reg = data[PW-1:0];
			ebp_pkg::REG_VERTEX_COUNT: verts_reg = data[VW-1:0];
			ebp_pkg::REG_EDGE_COUNT: edges_reg = data;
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_config(int unsigned np, int unsigned nv, logic [OW-1:0] ne);
		wait_quiet();
		write_reg(ebp_pkg::REG_PARTITION_COUNT, np);
		write_reg(ebp_pkg::REG_VERTEX_COUNT, nv);
		write_reg(ebp_pkg::REG_EDGE_COUNT, ne);
	endtask

	// well-formed csr offsets for vertices 0..nv-1, returns the edge total
	task automatic load_csr(int unsigned nv, int unsigned max_deg, output logic [OW-1:0] total);
		logic [OW-1:0] acc;
		acc = 0;
		for (int i = 0; i < nv; i++) begin
			load_entry(i, acc);
			acc += $urandom_range(0, max_deg);
		end
		total = acc;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset values, zero counts and the even split including its extremes
	task automatic test_even_split();
		run_partition();
		set_config(0, 0, 0);
		run_partition();
		set_config(63, 252, 32'hFFFF_FFFF);
		run_partition();
		set_config(63, 1, 0);
		run_partition();
		set_config(5, 20, 7);
		run_partition();
		set_config(40, 41, 0);
		run_partition();
		// upper data bits beyond each field must be dropped
		set_config(32'hFFFF_FFC7, 32'hFFFF_F00D, 32'h8000_0001);
		run_partition();
	endtask

	// directed runs: flat offsets, extreme values and a csr array; only the last searches
	task automatic test_search_directed();
		logic [OW-1:0] total;
		set_config(1, 5, 0);
		for (int i = 0; i < 8; i++)
			load_entry(i, 0);
		run_partition();
		set_config(2, 6, 0);
		run_partition();
		set_config(2, 8, 32'hFFFF_FFFF);
		load_entry(0, 32'hFFFF_FFFF);
		load_entry(1, 32'h5555_5555);
		load_entry(2, 32'hAAAA_AAAA);
		run_partition();
		set_config(3, 13, 0);
		load_csr(13, 9, total);
		set_config(3, 13, total);
		run_partition();
	endtask

	// the most partitions with a search over a long offset array
	task automatic test_full_store();
		logic [OW-1:0] total;
		set_config(1, 256, 0);
		load_csr(256, 3, total);
		set_config(63, 256, total);
		run_partition();
		set_config(7, 256, total);
		run_partition();
		set_config(63, 256, 32'hFFFF_FFFF);
		run_partition();
	endtask

	// the receiver holds off while runs and loads keep coming
	task automatic test_back_pressure();
		logic [OW-1:0] total;
		set_config(4, 30, 0);
		load_csr(30, 6, total);
		set_config(4, 30, total);
		hold_req = 1;
		run_partition();
		for (int i = 0; i < 12; i++)
			load_entry(100 + i, $urandom);
		run_partition();
		set_config(16, 40, 0);
		run_partition();
	endtask

	task automatic test_random();
		int unsigned items, np, nv, runs;
		logic [OW-1:0] total, ne;
		items = 0;
		while (items < 110) begin
			np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
			case ($urandom_range(0, 5))
				0: nv = $urandom_range(0, 4 * ((np == 0) ? 1 : np));
				5: nv = $urandom_range(100, 300);
				default: nv = $urandom_range(1, 48);
			endcase
			set_config(np, nv, 0);
			if ($urandom_range(0, 4) != 0) begin
				load_csr((nv == 0) ? 1 : nv, $urandom_range(0, 40), total);
				items += (nv == 0) ? 1 : nv;
			end else begin
				// noisy offsets with no order
				for (int i = 0; i < ((nv == 0) ? 1 : nv); i++)
					load_entry(i, $urandom);
				total = $urandom;
				items += (nv == 0) ? 1 : nv;
			end
			// stray loads away from the active range
			repeat ($urandom_range(0, 3)) begin
				load_entry($urandom_range(300, 4095), $urandom);
				items++;
			end
			case ($urandom_range(0, 5))
				0: ne = $urandom;
				1: ne = 0;
				default: ne = total + $urandom_range(0, 3);
			endcase
			set_config(np, nv, ne);
			runs = $urandom_range(1, 3);
			for (int r = 0; r < runs; r++) begin
				if (run_is_safe())
					run_partition();
				items++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		stall_pct = 0;
		hold_req = 0;
		parts_reg = 1;
		verts_reg = 1;
		edges_reg = 0;
		foreach (loaded[i]) begin
			loaded[i] = 0;
			offsets[i] = 0;
		end
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = ebp_pkg::CMD_LOAD;
		cmd_ch.offset_index = '0;
		cmd_ch.offset_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ebp_pkg::REG_PARTITION_COUNT;
		cfg_ch.data = '0;
		bord_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_even_split();
		test_search_directed();
		test_back_pressure();
		test_full_store();
		test_random();

		wait_quiet();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("** csr_edge_balanced_partitioner: PASSED **");
		else
			$display("** csr_edge_balanced_partitioner: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ebp_pkg.sv
hw/rtl/ebp_if.sv
hw/rtl/ebp_divider.sv
hw/rtl/csr_edge_balanced_partitioner.sv
hw/rtl/ebp_checker.sv
sim/tb_csr_edge_balanced_partitioner.sv
